[hdl/rotary_knob_cc_generator_unit_assert.svh]
// Assertion macros shared by the rotary knob CC generator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ROTARY_KNOB_CC_GENERATOR_UNIT_ASSERT_SVH
`define ROTARY_KNOB_CC_GENERATOR_UNIT_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define RKCC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("rkcc invariant violated");

// Antecedent implies consequent in the same cycle.
`define RKCC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rkcc implication violated");

// Antecedent implies consequent in the following cycle.
`define RKCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rkcc next-cycle check violated");

`endif

[hdl/rkcc_pkg.sv]
// Shared types and constants for the rotary knob CC generator.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package rkcc_pkg;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE_FLAGS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_NARROW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_WIDE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_POINT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTARY_CHANNEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_MSB    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_LSB    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCELERATION   = 3'd7;

   // Mode flag bit positions
   localparam int FLAG_REVERSE     = 0;
   localparam int FLAG_EXTENDED    = 1;
   localparam int FLAG_RELATIVE    = 2;
   localparam int FLAG_FLASH_ROT   = 3;
   localparam int FLAG_FLASH_LIMIT = 4;

   // Request command codes
   localparam logic [1:0] CMD_ROTATE = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_CC     = 2'd2;

   localparam logic [1:0] DIR_PLUS  = 2'b01;
   localparam logic [1:0] DIR_MINUS = 2'b11;

   localparam logic [7:0]  CC_STATUS_MASK = 8'hB0;
   localparam logic [3:0]  CC_PACKET_CODE = 4'hB;
   localparam logic [13:0] LIMIT_WIDE     = 14'h3fff;
   localparam logic [13:0] LIMIT_NARROW   = 14'h007f;
   localparam logic [5:0]  DECAY_PERIOD   = 6'd50;

   // Product of step (14 bits) and velocity+1 (15 bits)
   localparam int PROD_W = 29;

   // Command queue between front and back; depth is a power of two
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

   // Result record queue in front of the packet serializer; power of two
   localparam int RECQ_DEPTH = 2;
   localparam int RECQ_AW    = $clog2(RECQ_DEPTH);
   localparam int RECQ_CW    = $clog2(RECQ_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_ROTATE,
      OP_TICK,
      OP_LOAD_NARROW,
      OP_LOAD_HIGH,
      OP_LOAD_LOW
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       neg;
      logic [6:0] data;
   } cmd_type;

   typedef struct packed {
      logic [4:0]  mode_flags;
      logic [6:0]  step_narrow;
      logic [13:0] step_wide;
      logic [6:0]  zero_point;
      logic [3:0]  rotary_channel;
      logic [6:0]  control_msb;
      logic [6:0]  control_lsb;
      logic [7:0]  acceleration;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode_flags:     5'd0,
      step_narrow:    7'd1,
      step_wide:      14'd1,
      zero_point:     7'd64,
      rotary_channel: 4'd0,
      control_msb:    7'd7,
      control_lsb:    7'd39,
      acceleration:   8'd0
   };

   // One rotate outcome: one packet, or MSB then LSB
   typedef struct packed {
      logic [6:0] first;
      logic [6:0] second;
      logic       two;
      logic       flash;
   } rec_type;

endpackage

`default_nettype wire

[hdl/rkcc_front.sv]
// Request front end: acceptance and classification into queue commands.
// Depends on rkcc_pkg.
`default_nettype none

module rkcc_front
   import rkcc_pkg::*;
(
   input  var cfg_type           cfg,
   input  var logic              req_push,
   output var logic              req_full,
   input  var logic [1:0]        req_command,
   input  var logic signed [1:0] req_direction,
   input  var logic [7:0]        req_cc_status,
   input  var logic [6:0]        req_cc_number,
   input  var logic [6:0]        req_cc_value,
   input  var logic              cmdq_full,
   output var logic              cmdq_push,
   output var cmd_type           cmdq_data
);

   logic keep;
   logic chan_hit;
   logic ext;

   assign ext      = cfg.mode_flags[FLAG_EXTENDED];
   assign chan_hit = ((req_cc_status & CC_STATUS_MASK) == CC_STATUS_MASK)
                     && (req_cc_status[3:0] == cfg.rotary_channel);

   always_comb begin
      keep         = 1'b0;
      cmdq_data.op = OP_TICK;
      // Step goes down only when the effective direction is plus one
      cmdq_data.neg  = cfg.mode_flags[FLAG_REVERSE]
                       ? (req_direction == DIR_PLUS)
                       : (req_direction == DIR_MINUS);
      cmdq_data.data = req_cc_value;
      case (req_command)
         CMD_ROTATE: begin
            keep         = 1'b1;
            cmdq_data.op = OP_ROTATE;
         end
         CMD_TICK: begin
            keep         = 1'b1;
            cmdq_data.op = OP_TICK;
         end
         CMD_CC: begin
            if (chan_hit) begin
               if (ext) begin
                  if (req_cc_number == cfg.control_msb) begin
                     keep         = 1'b1;
                     cmdq_data.op = OP_LOAD_HIGH;
                  end else if (req_cc_number == cfg.control_lsb) begin
                     keep         = 1'b1;
                     cmdq_data.op = OP_LOAD_LOW;
                  end
               end else if (req_cc_number == cfg.control_msb) begin
                  keep         = 1'b1;
                  cmdq_data.op = OP_LOAD_NARROW;
               end
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Drop requests that change nothing; they are still accepted
   assign req_full  = cmdq_full;
   assign cmdq_push = req_push && !cmdq_full && keep;

endmodule

`default_nettype wire

[hdl/rkcc_cmd_queue.sv]
// Short command queue that decouples the front end from the execution back end.
// Depends on rkcc_pkg.
`default_nettype none
`include "rotary_knob_cc_generator_unit_assert.svh"

module rkcc_cmd_queue
   import rkcc_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    push,
   input  var cmd_type push_data,
   output var logic    full,
   input  var logic    pop,
   output var cmd_type pop_data,
   output var logic    empty
);

   localparam logic [CMDQ_CW-1:0] COUNT_FULL = CMDQ_CW'(CMDQ_DEPTH);

   cmd_type              mem_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == COUNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RKCC_ASSERT_ALWAYS(a_cmdq_bound, clock, reset, count_ff <= COUNT_FULL)

endmodule

`default_nettype wire

[hdl/rkcc_back.sv]
// Execution back end: velocity, decay, multiply stage and value update.
// Depends on rkcc_pkg.
`default_nettype none
`include "rotary_knob_cc_generator_unit_assert.svh"

module rkcc_back
   import rkcc_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var cfg_type cfg,
   input  var cmd_type cmd,
   input  var logic    cmd_empty,
   output var logic    cmd_pop,
   input  var logic    rec_full,
   output var logic    rec_push,
   output var rec_type rec
);

   logic ext;
   logic relative;
   logic [13:0] lim;

   logic [13:0] velocity_ff, velocity_in;
   logic [5:0]  decay_ff, decay_in;
   logic [6:0]  value_narrow_ff, value_narrow_in;
   logic [13:0] value_wide_ff, value_wide_in;

   logic              s1_valid_ff, s1_valid_in;
   op_type            s1_op_ff;
   logic              s1_neg_ff;
   logic [6:0]        s1_data_ff;
   logic [PROD_W-1:0] s1_prod_ff;

   logic              s1_fire;
   logic              s1_free;

   logic [13:0]       step;
   logic [14:0]       vel_plus;
   logic [PROD_W-1:0] prod;
   logic [14:0]       vel_sum;
   logic [13:0]       vel_sat;
   logic [5:0]        decay_next;

   logic [13:0]       cur;
   logic [PROD_W:0]   sum;
   logic              under;
   logic              over;
   logic [13:0]       diff;
   logic [13:0]       clamp;
   logic              hit;
   logic [6:0]        rel_data;
   logic              narrow_rotate;

   assign ext      = cfg.mode_flags[FLAG_EXTENDED];
   assign relative = cfg.mode_flags[FLAG_RELATIVE];
   assign lim      = ext ? LIMIT_WIDE : LIMIT_NARROW;

   // Stage 2 retires when it needs no record slot or one is free
   assign s1_fire = s1_valid_ff && ((s1_op_ff != OP_ROTATE) || !rec_full);
   assign s1_free = !s1_valid_ff || s1_fire;
   assign cmd_pop = !cmd_empty && s1_free;

   // Stage 1: step times velocity+1, velocity and decay bookkeeping
   assign step       = ext ? cfg.step_wide : {7'd0, cfg.step_narrow};
   assign vel_plus   = {1'b0, velocity_ff} + 15'd1;
   assign prod       = {15'd0, step} * {14'd0, vel_plus};
   assign vel_sum    = {1'b0, velocity_ff} + {7'd0, cfg.acceleration};
   assign vel_sat    = (vel_sum >= {1'b0, lim}) ? lim : vel_sum[13:0];
   assign decay_next = decay_ff + 6'd1;

   always_comb begin
      velocity_in = velocity_ff;
      decay_in    = decay_ff;
      if (cmd_pop) begin
         case (cmd.op)
            OP_ROTATE: begin
               velocity_in = vel_sat;
               decay_in    = '0;
            end
            OP_TICK: begin
               if (decay_next == DECAY_PERIOD) begin
                  decay_in    = '0;
                  velocity_in = velocity_ff >> 1;
               end else begin
                  decay_in = decay_next;
               end
            end
            default: begin
               velocity_in = velocity_ff;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (cmd_pop) begin
         s1_valid_in = (cmd.op != OP_TICK);
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Stage 2: clamp against the stored value, or wrap around the zero point
   assign cur      = ext ? value_wide_ff : {7'd0, value_narrow_ff};
   assign sum      = {16'd0, cur} + {1'b0, s1_prod_ff};
   assign under    = s1_prod_ff > {15'd0, cur};
   assign over     = sum > {16'd0, lim};
   assign diff     = cur - s1_prod_ff[13:0];
   assign rel_data = s1_neg_ff ? (cfg.zero_point - s1_prod_ff[6:0])
                               : (cfg.zero_point + s1_prod_ff[6:0]);

   always_comb begin
      if (s1_neg_ff) begin
         clamp = under ? 14'd0 : diff;
         hit   = under;
      end else begin
         clamp = over ? lim : sum[13:0];
         hit   = over;
      end
   end

   always_comb begin
      rec.second = clamp[6:0];
      if (relative) begin
         rec.first = rel_data;
         rec.two   = 1'b0;
         rec.flash = cfg.mode_flags[FLAG_FLASH_ROT];
      end else begin
         rec.first = ext ? clamp[13:7] : clamp[6:0];
         rec.two   = ext;
         rec.flash = cfg.mode_flags[FLAG_FLASH_ROT]
                     || (hit && cfg.mode_flags[FLAG_FLASH_LIMIT]);
      end
   end

   assign rec_push = s1_valid_ff && (s1_op_ff == OP_ROTATE) && !rec_full;

   always_comb begin
      value_narrow_in = value_narrow_ff;
      value_wide_in   = value_wide_ff;
      if (s1_fire) begin
         case (s1_op_ff)
            OP_ROTATE: begin
               if (!relative) begin
                  if (ext) begin
                     value_wide_in = clamp;
                  end else begin
                     value_narrow_in = clamp[6:0];
                  end
               end
            end
            OP_LOAD_NARROW: begin
               value_narrow_in = s1_data_ff;
            end
            OP_LOAD_HIGH: begin
               value_wide_in = {s1_data_ff, value_wide_ff[6:0]};
            end
            OP_LOAD_LOW: begin
               value_wide_in = {value_wide_ff[13:7], s1_data_ff};
            end
            default: begin
               value_wide_in = value_wide_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_ff     <= '0;
         decay_ff        <= '0;
         value_narrow_ff <= '0;
         value_wide_ff   <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         velocity_ff     <= velocity_in;
         decay_ff        <= decay_in;
         value_narrow_ff <= value_narrow_in;
         value_wide_ff   <= value_wide_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s1_op_ff   <= cmd.op;
         s1_neg_ff  <= cmd.neg;
         s1_data_ff <= cmd.data;
         s1_prod_ff <= prod;
      end
   end

   assign narrow_rotate = cmd_pop && (cmd.op == OP_ROTATE) && !ext;

   `RKCC_ASSERT_NEXT(a_vel_narrow, clock, reset, narrow_rotate, velocity_ff <= LIMIT_NARROW)

endmodule

`default_nettype wire

[hdl/rkcc_emit.sv]
// Result record queue and packet serializer (MSB then LSB in 14-bit absolute mode).
// Depends on rkcc_pkg.
`default_nettype none
`include "rotary_knob_cc_generator_unit_assert.svh"

module rkcc_emit
   import rkcc_pkg::*;
(
   input  var logic       clock,
   input  var logic       reset,
   input  var cfg_type    cfg,
   input  var logic       rec_push,
   input  var rec_type    rec,
   output var logic       rec_full,
   output var logic       rsp_empty,
   input  var logic       rsp_pop,
   output var logic [3:0] rsp_packet_header,
   output var logic [7:0] rsp_status_byte,
   output var logic [6:0] rsp_controller,
   output var logic [6:0] rsp_data_value,
   output var logic       rsp_last,
   output var logic       rsp_blink
);

   localparam logic [RECQ_CW-1:0] COUNT_FULL = RECQ_CW'(RECQ_DEPTH);

   rec_type            mem_ff [RECQ_DEPTH];
   logic [RECQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RECQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RECQ_CW-1:0] count_ff, count_in;
   logic               half_ff, half_in;
   rec_type            head;
   logic               pop_ok;
   logic               deq;

   assign head      = mem_ff[rd_ptr_ff];
   assign rec_full  = (count_ff == COUNT_FULL);
   assign rsp_empty = (count_ff == '0);
   assign pop_ok    = rsp_pop && !rsp_empty;
   // Retire the record after its final packet
   assign deq       = pop_ok && (!head.two || half_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      half_in   = half_ff;
      if (rec_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (rec_push && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !rec_push) begin
         count_in = count_ff - 1'b1;
      end
      if (pop_ok) begin
         half_in = head.two && !half_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         half_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         half_ff   <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_push) begin
         mem_ff[wr_ptr_ff] <= rec;
      end
   end

   assign rsp_packet_header = CC_PACKET_CODE;
   assign rsp_status_byte   = CC_STATUS_MASK | {4'd0, cfg.rotary_channel};
   assign rsp_controller    = half_ff ? cfg.control_lsb : cfg.control_msb;
   assign rsp_data_value    = half_ff ? head.second : head.first;
   assign rsp_last          = !head.two || half_ff;
   assign rsp_blink         = head.flash;

   `RKCC_ASSERT_ALWAYS(a_recq_bound, clock, reset, count_ff <= COUNT_FULL)
   `RKCC_ASSERT_IMPLIES(a_half_valid, clock, reset, half_ff, !rsp_empty && head.two)

endmodule

`default_nettype wire

[hdl/rotary_knob_cc_generator_unit.sv]
// Rotary knob CC generator top: registers, front, queue, back, emitter; uses rkcc_pkg.
// A rotate request is registered in the command queue, stage 1 and the record queue.
// Throughput: one request per cycle while req_full is low; a 14-bit absolute rotate
//   takes two pops of the result port (MSB then LSB).
// Reset: synchronous, active high; clears queues and knob state and restores
//   register defaults. No clearing pass.
`default_nettype none

module rotary_knob_cc_generator_unit
   import rkcc_pkg::*;
(
   input  var logic                  clock,
   input  var logic                  reset,
   // Request channel
   input  var logic                  req_push,
   output var logic                  req_full,
   input  var logic [1:0]            req_command,
   input  var logic signed [1:0]     req_direction,
   input  var logic [7:0]            req_cc_status,
   input  var logic [6:0]            req_cc_number,
   input  var logic [6:0]            req_cc_value,
   // Result channel
   output var logic                  rsp_empty,
   input  var logic                  rsp_pop,
   output var logic [3:0]            rsp_packet_header,
   output var logic [7:0]            rsp_status_byte,
   output var logic [6:0]            rsp_controller,
   output var logic [6:0]            rsp_data_value,
   output var logic                  rsp_last,
   output var logic                  rsp_blink,
   // Register write port
   input  var logic                  csr_write,
   input  var logic [CSR_IDX_W-1:0]  csr_index,
   input  var logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic    cmdq_push;
   cmd_type cmdq_wdata;
   logic    cmdq_full;
   logic    cmdq_pop;
   cmd_type cmdq_rdata;
   logic    cmdq_empty;

   logic    rec_push;
   rec_type rec;
   logic    rec_full;

   // Register file: update the addressed field, hold the rest
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MODE_FLAGS:     cfg_in.mode_flags     = csr_data[4:0];
            CSR_STEP_NARROW:    cfg_in.step_narrow    = csr_data[6:0];
            CSR_STEP_WIDE:      cfg_in.step_wide      = csr_data[13:0];
            CSR_ZERO_POINT:     cfg_in.zero_point     = csr_data[6:0];
            CSR_ROTARY_CHANNEL: cfg_in.rotary_channel = csr_data[3:0];
            CSR_CONTROL_MSB:    cfg_in.control_msb    = csr_data[6:0];
            CSR_CONTROL_LSB:    cfg_in.control_lsb    = csr_data[6:0];
            CSR_ACCELERATION:   cfg_in.acceleration   = csr_data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: decode requests, drop the ones that change nothing
   rkcc_front u_front (
      .cfg           (cfg_ff),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_direction (req_direction),
      .req_cc_status (req_cc_status),
      .req_cc_number (req_cc_number),
      .req_cc_value  (req_cc_value),
      .cmdq_full     (cmdq_full),
      .cmdq_push     (cmdq_push),
      .cmdq_data     (cmdq_wdata)
   );

   // Decouple acceptance from execution
   rkcc_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmdq_push),
      .push_data (cmdq_wdata),
      .full      (cmdq_full),
      .pop       (cmdq_pop),
      .pop_data  (cmdq_rdata),
      .empty     (cmdq_empty)
   );

   // Back: multiply in one stage, clamp and update value in the next
   rkcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmdq_rdata),
      .cmd_empty (cmdq_empty),
      .cmd_pop   (cmdq_pop),
      .rec_full  (rec_full),
      .rec_push  (rec_push),
      .rec       (rec)
   );

   // Split each rotate outcome into one or two CC packets
   rkcc_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .rec_push          (rec_push),
      .rec               (rec),
      .rec_full          (rec_full),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_packet_header (rsp_packet_header),
      .rsp_status_byte   (rsp_status_byte),
      .rsp_controller    (rsp_controller),
      .rsp_data_value    (rsp_data_value),
      .rsp_last          (rsp_last),
      .rsp_blink         (rsp_blink)
   );

endmodule

`default_nettype wire

[verif/tb_rotary_knob_cc_generator_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for the rotary knob CC generator: queued request driver,
// popping result monitor and an in-bench knob predictor. Depends on rkcc_pkg
// and the rotary_knob_cc_generator_unit RTL.

module tb_rotary_knob_cc_generator_unit;
   import rkcc_pkg::*;

   // Command code the block ignores, and the two odd encoder directions
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] DIR_ZERO   = 2'b00;
   localparam logic [1:0] DIR_FAR    = 2'b10;

   localparam int RANDOM_PHASES   = 11;
   localparam int ITEMS_PER_PHASE = 95;
   // Four-entry command queue plus pipeline; ticks and CCs make no result,
   // so give them time to retire before touching the registers.
   localparam int DRAIN_CYCLES    = 24;

   typedef struct {
      logic [1:0] command;
      logic [1:0] direction;  // raw two's complement encoder step
      logic [7:0] cc_status;
      logic [6:0] cc_number;
      logic [6:0] cc_value;
   } knob_req_type;

   typedef struct {
      logic [3:0] header;
      logic [7:0] status;
      logic [6:0] controller;
      logic [6:0] data;
      logic       last;
      logic       flash;
   } cc_packet_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [1:0]            req_command = '0;
   logic signed [1:0]     req_direction = '0;
   logic [7:0]            req_cc_status = '0;
   logic [6:0]            req_cc_number = '0;
   logic [6:0]            req_cc_value = '0;

   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [3:0]            rsp_packet_header;
   logic [7:0]            rsp_status_byte;
   logic [6:0]            rsp_controller;
   logic [6:0]            rsp_data_value;
   logic                  rsp_last;
   logic                  rsp_blink;

   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   rotary_knob_cc_generator_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_command       (req_command),
      .req_direction     (req_direction),
      .req_cc_status     (req_cc_status),
      .req_cc_number     (req_cc_number),
      .req_cc_value      (req_cc_value),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_packet_header (rsp_packet_header),
      .rsp_status_byte   (rsp_status_byte),
      .rsp_controller    (rsp_controller),
      .rsp_data_value    (rsp_data_value),
      .rsp_last          (rsp_last),
      .rsp_blink         (rsp_blink),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow registers and knob state, tracked request by request
   cfg_type     knob_cfg = CFG_RESET;
   logic [6:0]  level7 = '0;
   logic [13:0] level14 = '0;
   logic [13:0] speed = '0;
   logic [5:0]  idle_ticks = '0;

   knob_req_type  knob_backlog[$];
   cc_packet_type cc_packets_due[$];

   int requests_queued = 0;
   int requests_taken  = 0;
   int packets_checked = 0;
   int decay_count     = 0;
   int clamp_count     = 0;
   int mismatch_count  = 0;

   int push_hold = 0;
   int push_calm = 0;
   int pop_hold  = 0;
   int pop_calm  = 0;

   // Mostly short pauses, a few long ones, and now and then a calm stretch
   // with none at all.
   function automatic int pick_pause(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 149) == 0) begin
         calm = $urandom_range(40, 160);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 9);
      return $urandom_range(10, 40);
   endfunction

   function automatic void emit_packet(logic [6:0] ctrl, logic [6:0] data, logic last,
                                       logic flash);
      cc_packet_type pk;
      pk.header     = CC_PACKET_CODE;
      pk.status     = CC_STATUS_MASK | {4'h0, knob_cfg.rotary_channel};
      pk.controller = ctrl;
      pk.data       = data;
      pk.last       = last;
      pk.flash      = flash;
      cc_packets_due.push_back(pk);
   endfunction

   // Advance the knob by one accepted request and queue the packets it sends.
   function automatic void apply_knob_request(knob_req_type rq);
      int   dir, mag, delta, lim, cur, vel_next;
      logic ext, hit, flash;
      case (rq.command)
         CMD_ROTATE: begin
            ext = knob_cfg.mode_flags[FLAG_EXTENDED];
            dir = rq.direction[1] ? int'(rq.direction) - 4 : int'(rq.direction);
            if (!knob_cfg.mode_flags[FLAG_REVERSE]) dir = -dir;
            mag = ext ? int'(knob_cfg.step_wide) : int'(knob_cfg.step_narrow);
            // only an effective +1 turns the step negative; odd values step up
            if (dir == 1) mag = -mag;
            delta = mag * (int'(speed) + 1);
            lim = ext ? int'(LIMIT_WIDE) : int'(LIMIT_NARROW);
            if (knob_cfg.mode_flags[FLAG_RELATIVE]) begin
               emit_packet(knob_cfg.control_msb, 7'(int'(knob_cfg.zero_point) + delta),
                           1'b1, knob_cfg.mode_flags[FLAG_FLASH_ROT]);
            end else begin
               cur = (ext ? int'(level14) : int'(level7)) + delta;
               hit = 1'b0;
               if (cur < 0) begin
                  cur = 0;
                  hit = 1'b1;
               end else if (cur > lim) begin
                  cur = lim;
                  hit = 1'b1;
               end
               if (hit) clamp_count++;
               flash = knob_cfg.mode_flags[FLAG_FLASH_ROT] |
                       (hit & knob_cfg.mode_flags[FLAG_FLASH_LIMIT]);
               if (ext) begin
                  level14 = 14'(cur);
                  emit_packet(knob_cfg.control_msb, level14[13:7], 1'b0, flash);
                  emit_packet(knob_cfg.control_lsb, level14[6:0], 1'b1, flash);
               end else begin
                  level7 = 7'(cur);
                  emit_packet(knob_cfg.control_msb, level7, 1'b1, flash);
               end
            end
            vel_next = int'(speed) + int'(knob_cfg.acceleration);
            if (vel_next >= lim) vel_next = lim;
            speed = 14'(vel_next);
            idle_ticks = '0;
         end
         CMD_TICK: begin
            idle_ticks = idle_ticks + 6'd1;
            if (idle_ticks == DECAY_PERIOD) begin
               idle_ticks = '0;
               speed = speed >> 1;
               decay_count++;
            end
         end
         CMD_CC: begin
            if ((rq.cc_status & CC_STATUS_MASK) == CC_STATUS_MASK &&
                rq.cc_status[3:0] == knob_cfg.rotary_channel) begin
               if (knob_cfg.mode_flags[FLAG_EXTENDED]) begin
                  if (rq.cc_number == knob_cfg.control_msb)
                     level14[13:7] = rq.cc_value;
                  else if (rq.cc_number == knob_cfg.control_lsb)
                     level14[6:0] = rq.cc_value;
               end else if (rq.cc_number == knob_cfg.control_msb) begin
                  level7 = rq.cc_value;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Request driver: hold each request on the port until the block takes it,
   // then pause at random before presenting the next one.
   knob_req_type on_port;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            apply_knob_request(on_port);
            requests_taken++;
         end
         if (!req_push || !req_full) begin
            if (push_hold > 0) begin
               push_hold--;
               req_push <= 1'b0;
            end else if (knob_backlog.size() != 0) begin
               on_port = knob_backlog.pop_front();
               req_command   <= on_port.command;
               req_direction <= on_port.direction;
               req_cc_status <= on_port.cc_status;
               req_cc_number <= on_port.cc_number;
               req_cc_value  <= on_port.cc_value;
               req_push      <= 1'b1;
               push_hold = pick_pause(push_calm);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Result monitor: compare every popped packet against the oldest one due.
   always @(posedge clock) begin : result_monitor
      cc_packet_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (cc_packets_due.size() == 0) begin
               $error("unexpected packet: controller 0x%0h data 0x%0h",
                      rsp_controller, rsp_data_value);
               mismatch_count++;
            end else begin
               want = cc_packets_due.pop_front();
               check_field("packet_header", 16'(want.header), 16'(rsp_packet_header));
               check_field("status_byte", 16'(want.status), 16'(rsp_status_byte));
               check_field("controller", 16'(want.controller), 16'(rsp_controller));
               check_field("data_value", 16'(want.data), 16'(rsp_data_value));
               check_field("last", 16'(want.last), 16'(rsp_last));
               check_field("blink", 16'(want.flash), 16'(rsp_blink));
               packets_checked++;
            end
         end
         if (pop_hold > 0) begin
            pop_hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_hold = pick_pause(pop_calm);
         end
      end
   end

   task automatic queue_request(logic [1:0] cmd, logic [1:0] dir, logic [7:0] st,
                                logic [6:0] num, logic [6:0] val);
      knob_req_type rq;
      rq.command   = cmd;
      rq.direction = dir;
      rq.cc_status = st;
      rq.cc_number = num;
      rq.cc_value  = val;
      knob_backlog.push_back(rq);
      requests_queued++;
   endtask

   // Wait until every request is taken and every packet has come back, then
   // let queued ticks and CCs retire.
   task automatic wait_idle();
      while (requests_taken != requests_queued || cc_packets_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         CSR_MODE_FLAGS:     knob_cfg.mode_flags     = data[4:0];
         CSR_STEP_NARROW:    knob_cfg.step_narrow    = data[6:0];
         CSR_STEP_WIDE:      knob_cfg.step_wide      = data[13:0];
         CSR_ZERO_POINT:     knob_cfg.zero_point     = data[6:0];
         CSR_ROTARY_CHANNEL: knob_cfg.rotary_channel = data[3:0];
         CSR_CONTROL_MSB:    knob_cfg.control_msb    = data[6:0];
         CSR_CONTROL_LSB:    knob_cfg.control_lsb    = data[6:0];
         CSR_ACCELERATION:   knob_cfg.acceleration   = data[7:0];
         default: ;
      endcase
   endtask

   task automatic program_knob(cfg_type c);
      write_csr(CSR_MODE_FLAGS, 14'(c.mode_flags));
      write_csr(CSR_STEP_NARROW, 14'(c.step_narrow));
      write_csr(CSR_STEP_WIDE, c.step_wide);
      write_csr(CSR_ZERO_POINT, 14'(c.zero_point));
      write_csr(CSR_ROTARY_CHANNEL, 14'(c.rotary_channel));
      write_csr(CSR_CONTROL_MSB, 14'(c.control_msb));
      write_csr(CSR_CONTROL_LSB, 14'(c.control_lsb));
      write_csr(CSR_ACCELERATION, 14'(c.acceleration));
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      cfg_type    next_cfg;
      int         ph, made, r, n, k;
      logic [1:0] cmd;
      logic [7:0] st;
      logic [6:0] num;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, register defaults: step down into the floor, both odd
      // directions, overwrite from a CC, clamp at the top, CC filtering,
      // a tick and the unused command.
      queue_request(CMD_ROTATE, DIR_MINUS, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_ROTATE, DIR_PLUS, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_ROTATE, DIR_ZERO, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_ROTATE, DIR_FAR, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_CC, DIR_ZERO, CC_STATUS_MASK, 7'd7, 7'd127);
      queue_request(CMD_ROTATE, DIR_PLUS, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_CC, DIR_ZERO, CC_STATUS_MASK | 8'h01, 7'd7, 7'd0);
      queue_request(CMD_CC, DIR_ZERO, 8'hA0, 7'd7, 7'd0);
      queue_request(CMD_CC, DIR_ZERO, 8'hF0, 7'd7, 7'd5);
      queue_request(CMD_CC, DIR_ZERO, CC_STATUS_MASK, 7'd39, 7'd90);
      queue_request(CMD_TICK, DIR_ZERO, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_UNUSED, DIR_FAR, 8'hFF, 7'd127, 7'd127);
      queue_request(CMD_ROTATE, DIR_MINUS, 8'h00, 7'd0, 7'd0);
      wait_idle();

      // Directed, 14-bit reversed with full steps and acceleration: load both
      // halves by CC, run to zero, then slam into the top limit.
      next_cfg = CFG_RESET;
      next_cfg.mode_flags = '0;
      next_cfg.mode_flags[FLAG_REVERSE]     = 1'b1;
      next_cfg.mode_flags[FLAG_EXTENDED]    = 1'b1;
      next_cfg.mode_flags[FLAG_FLASH_LIMIT] = 1'b1;
      next_cfg.step_wide      = LIMIT_WIDE;
      next_cfg.rotary_channel = 4'hF;
      next_cfg.control_msb    = 7'd127;
      next_cfg.control_lsb    = 7'd0;
      next_cfg.acceleration   = 8'd255;
      program_knob(next_cfg);
      queue_request(CMD_CC, DIR_ZERO, CC_STATUS_MASK | 8'h0F, 7'd127, 7'd127);
      queue_request(CMD_CC, DIR_ZERO, CC_STATUS_MASK | 8'h0F, 7'd0, 7'd127);
      queue_request(CMD_ROTATE, DIR_PLUS, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_ROTATE, DIR_MINUS, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_ROTATE, DIR_MINUS, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_TICK, DIR_ZERO, 8'h00, 7'd0, 7'd0);
      wait_idle();

      // Directed, relative 14-bit step around a zero point of zero, flashing.
      next_cfg.mode_flags = '0;
      next_cfg.mode_flags[FLAG_EXTENDED]  = 1'b1;
      next_cfg.mode_flags[FLAG_RELATIVE]  = 1'b1;
      next_cfg.mode_flags[FLAG_FLASH_ROT] = 1'b1;
      next_cfg.zero_point = 7'd0;
      program_knob(next_cfg);
      queue_request(CMD_ROTATE, DIR_PLUS, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_ROTATE, DIR_MINUS, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_ROTATE, DIR_ZERO, 8'h00, 7'd0, 7'd0);
      queue_request(CMD_ROTATE, DIR_FAR, 8'h00, 7'd0, 7'd0);

      // Random phases: the all-low and all-high settings first, then random
      // ones biased toward small steps so the value wanders before clamping.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: next_cfg = '0;
            1: next_cfg = '1;
            default: begin
               next_cfg.mode_flags = 5'($urandom_range(0, 31));
               r = $urandom_range(0, 9);
               next_cfg.step_narrow = (r < 5) ? 7'($urandom_range(0, 3)) :
                                      (r < 9) ? 7'($urandom_range(0, 127)) : 7'd127;
               r = $urandom_range(0, 9);
               next_cfg.step_wide = (r < 4) ? 14'($urandom_range(0, 3)) :
                                    (r < 7) ? 14'($urandom_range(0, 300)) :
                                    (r < 9) ? 14'($urandom_range(0, 16383)) : LIMIT_WIDE;
               next_cfg.zero_point     = 7'($urandom_range(0, 127));
               next_cfg.rotary_channel = 4'($urandom_range(0, 15));
               next_cfg.control_msb    = 7'($urandom_range(0, 127));
               next_cfg.control_lsb    = ($urandom_range(0, 7) == 0) ?
                                         next_cfg.control_msb : 7'($urandom_range(0, 127));
               r = $urandom_range(0, 9);
               next_cfg.acceleration = (r < 2) ? 8'd0 : (r < 6) ? 8'($urandom_range(1, 8)) :
                                       (r < 9) ? 8'($urandom_range(0, 255)) : 8'd255;
            end
         endcase
         wait_idle();
         program_knob(next_cfg);

         made = 0;
         while (made < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               // a spin of detents, mostly clean plus or minus one
               n = $urandom_range(1, 12);
               repeat (n)
                  queue_request(CMD_ROTATE,
                                ($urandom_range(0, 99) < 85) ?
                                   ($urandom_range(0, 1) ? DIR_PLUS : DIR_MINUS) :
                                   2'($urandom_range(0, 3)),
                                8'($urandom), 7'($urandom), 7'($urandom));
               made += n;
            end else if (r < 70) begin
               // short pause, or one long enough to decay the speed
               n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) :
                                                  $urandom_range(45, 100);
               repeat (n)
                  queue_request(CMD_TICK, 2'($urandom), 8'($urandom), 7'($urandom),
                                7'($urandom));
               made += n;
            end else if (r < 90) begin
               st = ($urandom_range(0, 9) < 7) ?
                    (CC_STATUS_MASK | {4'h0, knob_cfg.rotary_channel}) : 8'($urandom);
               k = $urandom_range(0, 9);
               num = (k < 4) ? knob_cfg.control_msb :
                     (k < 8) ? knob_cfg.control_lsb : 7'($urandom);
               queue_request(CMD_CC, 2'($urandom), st, num, 7'($urandom));
               made++;
            end else if (r < 97) begin
               // noise: anything at all in every field
               n = $urandom_range(1, 4);
               repeat (n) begin
                  cmd = 2'($urandom_range(0, 3));
                  queue_request(cmd, 2'($urandom), 8'($urandom), 7'($urandom),
                                7'($urandom));
                  if (cmd != CMD_UNUSED) made++;
               end
            end else begin
               queue_request(CMD_UNUSED, 2'($urandom), 8'($urandom), 7'($urandom),
                             7'($urandom));
            end
         end
      end

      wait_idle();
      $display("Covered %0d requests over %0d register settings; %0d packets checked.",
               requests_taken, RANDOM_PHASES + 3, packets_checked);
      $display("Value clamps seen: %0d, speed decays seen: %0d, mismatches: %0d.",
               clamp_count, decay_count, mismatch_count);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/rkcc_pkg.sv
hdl/rkcc_front.sv
hdl/rkcc_cmd_queue.sv
hdl/rkcc_back.sv
hdl/rkcc_emit.sv
hdl/rotary_knob_cc_generator_unit.sv
verif/tb_rotary_knob_cc_generator_unit.sv
